/* src/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CMD_W       = 2;
    localparam int DATA_W      = 32;
    localparam int PRIO_W      = 16;
    localparam int STATUS_W    = 2;
    localparam int OCC_W       = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DEQ  = 2'd1,
        CMD_PEEK = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_HEAD,
        S_SCAN,
        S_PLACE,
        S_RESP
    } state_t;

    // One stored entry, as held in the entry RAM.
    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic signed [DATA_W-1:0] data;
    } entry_t;

    // Finished result from the sequencer to the output stage.
    typedef struct packed {
        logic                     valid;
        status_t                  status;
        logic signed [DATA_W-1:0] data;
        logic signed [PRIO_W-1:0] prio;
        logic [OCC_W-1:0]         occupancy;
    } result_t;

endpackage

/* src/spq_req_if.sv */
// Command channel: valid/ready plus command, data word and priority.
interface spq_req_if;
    logic                             valid;
    logic                             ready;
    logic [spq_pkg::CMD_W-1:0]        cmd;
    logic signed [spq_pkg::DATA_W-1:0] item_data;
    logic signed [spq_pkg::PRIO_W-1:0] item_priority;

    modport source (output valid, output cmd, output item_data, output item_priority,
                    input ready);
    modport sink   (input valid, input cmd, input item_data, input item_priority,
                    output ready);
endinterface

/* src/spq_rsp_if.sv */
// Result channel: valid/ready plus status, head entry and occupancy.
interface spq_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [spq_pkg::STATUS_W-1:0]      status;
    logic signed [spq_pkg::DATA_W-1:0] head_data;
    logic signed [spq_pkg::PRIO_W-1:0] head_priority;
    logic [spq_pkg::OCC_W-1:0]         occupancy;

    modport source (output valid, output status, output head_data, output head_priority,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input head_data, input head_priority,
                    input occupancy, output ready);
endinterface

/* src/spq_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/spq_ctrl.sv */
// Command sequencer: head pointer, fill count and read-modify-write of the entry RAM.
module spq_ctrl #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH,
    localparam int IDX_W      = $clog2(QUEUE_DEPTH),
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    spq_req_if.sink            req,
    input  logic               out_free,
    output spq_pkg::result_t   res,
    output logic               mem_we,
    output logic [IDX_W-1:0]   mem_waddr,
    output spq_pkg::entry_t    mem_wdata,
    output logic               mem_re,
    output logic [IDX_W-1:0]   mem_raddr,
    input  spq_pkg::entry_t    mem_rdata
);

    localparam logic [IDX_W:0]   DEPTH_WIDE = (IDX_W + 1)'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(QUEUE_DEPTH);

    spq_pkg::state_t  state_reg, state_next;
    spq_pkg::cmd_t    cmd_reg, cmd_next;
    spq_pkg::entry_t  new_reg, new_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    spq_pkg::status_t res_status_reg, res_status_next;
    spq_pkg::entry_t  res_entry_reg, res_entry_next;
    logic             shift_up;

    // Logical position (0 = head) to RAM address, circular.
    function automatic logic [IDX_W-1:0] to_phys(input logic [IDX_W-1:0] head,
                                                 input logic [IDX_W-1:0] lidx);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, lidx};
        if (sum >= DEPTH_WIDE)
        begin
            sum = sum - DEPTH_WIDE;
        end
        return sum[IDX_W-1:0];
    endfunction

    assign req.ready = (state_reg == spq_pkg::S_IDLE);
    assign shift_up  = (mem_rdata.prio >= new_reg.prio);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spq_pkg::S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        new_reg        <= new_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        new_next        = new_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = new_reg;
        mem_re          = 1'b0;
        mem_raddr       = head_reg;

        case (state_reg)
            spq_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next      = spq_pkg::cmd_t'(req.cmd);
                    new_next.data = req.item_data;
                    new_next.prio = req.item_priority;
                    state_next    = spq_pkg::S_START;
                end
            end

            spq_pkg::S_START:
            begin
                res_status_next = spq_pkg::STATUS_OK;
                res_entry_next  = '0;
                state_next      = spq_pkg::S_RESP;
                case (cmd_reg)
                    spq_pkg::CMD_ENQ:
                    begin
                        if (count_reg == CNT_FULL)
                        begin
                            res_status_next = spq_pkg::STATUS_FULL;
                        end
                        else if (count_reg == '0)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = head_reg;
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            // walk down from the tail
                            idx_next   = IDX_W'(count_reg - 1'b1);
                            mem_re     = 1'b1;
                            mem_raddr  = to_phys(head_reg, IDX_W'(count_reg - 1'b1));
                            state_next = spq_pkg::S_SCAN;
                        end
                    end
                    spq_pkg::CMD_DEQ, spq_pkg::CMD_PEEK:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = spq_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = head_reg;
                            state_next = spq_pkg::S_HEAD;
                        end
                    end
                    default:
                    begin
                        res_status_next = spq_pkg::STATUS_OK;
                    end
                endcase
            end

            spq_pkg::S_HEAD:
            begin
                res_entry_next = mem_rdata;
                if (cmd_reg == spq_pkg::CMD_DEQ)
                begin
                    head_next  = to_phys(head_reg, IDX_W'(1));
                    count_next = count_reg - 1'b1;
                end
                state_next = spq_pkg::S_RESP;
            end

            spq_pkg::S_SCAN:
            begin
                // entry at idx_reg is on the read port
                mem_we    = 1'b1;
                mem_waddr = to_phys(head_reg, idx_reg + 1'b1);
                if (shift_up)
                begin
                    mem_wdata = mem_rdata;
                    if (idx_reg == '0)
                    begin
                        state_next = spq_pkg::S_PLACE;
                    end
                    else
                    begin
                        idx_next  = idx_reg - 1'b1;
                        mem_re    = 1'b1;
                        mem_raddr = to_phys(head_reg, idx_reg - 1'b1);
                    end
                end
                else
                begin
                    mem_wdata  = new_reg;
                    count_next = count_reg + 1'b1;
                    state_next = spq_pkg::S_RESP;
                end
            end

            spq_pkg::S_PLACE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = head_reg;
                mem_wdata  = new_reg;
                count_next = count_reg + 1'b1;
                state_next = spq_pkg::S_RESP;
            end

            spq_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    state_next = spq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = spq_pkg::S_IDLE;
            end
        endcase
    end

    assign res.valid     = (state_reg == spq_pkg::S_RESP);
    assign res.status    = res_status_reg;
    assign res.data      = res_entry_reg.data;
    assign res.prio      = res_entry_reg.prio;
    assign res.occupancy = spq_pkg::OCC_W'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("fill count above depth");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> state_reg == spq_pkg::S_START)
        else $error("accepted transaction not started");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == spq_pkg::S_START || state_reg == spq_pkg::S_SCAN ||
                    state_reg == spq_pkg::S_PLACE))
        else $error("RAM write outside insert sequence");

    a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == spq_pkg::S_HEAD |-> count_reg != '0)
        else $error("head read on empty queue");

    a_scan_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == spq_pkg::S_SCAN |-> count_reg != CNT_FULL)
        else $error("insert walk on full queue");

endmodule

/* src/sorted_priority_queue_unit.sv */
// Sorted priority queue: a bounded min-priority queue whose entries sit in one
// synchronous RAM as a circular list in ascending priority order (signed), head
// first. Each command transaction on req (enqueue, dequeue, peek) produces
// exactly one result transaction on rsp with a status (ok, empty, full), the
// head entry for a successful dequeue or peek (zero otherwise) and the
// occupancy after the command. An enqueue goes ahead of all stored entries of
// equal priority; an enqueue on a full queue is dropped with status full.
// Commands are handled one at a time. Status-only results (full, empty, unused
// code) and an enqueue into an empty queue need no RAM read; dequeue and peek
// make one RAM read of the head; an enqueue into a non-empty queue walks down
// from the tail and moves each stored entry with priority greater than or equal
// to the new one up by one slot, one RAM read-and-write per cycle. Dequeue only
// advances the head pointer, so it costs no moves. The result is held in an
// output register, so the next command is taken while a finished result still
// waits on rsp. The RAM needs no clearing after reset; only entries below the
// fill count are ever read.
module sorted_priority_queue_unit #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH
) (
    input  logic     clk,
    input  logic     rst_n,
    spq_req_if.sink  req,
    spq_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    spq_pkg::result_t res;
    spq_pkg::entry_t  mem_wdata;
    spq_pkg::entry_t  mem_rdata;
    logic             mem_we;
    logic             mem_re;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    logic             out_free;

    // Output register: one result held until the sink takes it.
    logic                                out_valid_reg;
    logic [spq_pkg::STATUS_W-1:0]        out_status_reg;
    logic signed [spq_pkg::DATA_W-1:0]   out_data_reg;
    logic signed [spq_pkg::PRIO_W-1:0]   out_prio_reg;
    logic [spq_pkg::OCC_W-1:0]           out_occ_reg;

    assign out_free = !out_valid_reg || rsp.ready;

    spq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .out_free  (out_free),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Entry store: {priority, data} per slot.
    spq_ram #(
        .WIDTH ($bits(spq_pkg::entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && out_free)
        begin
            out_status_reg <= res.status;
            out_data_reg   <= res.data;
            out_prio_reg   <= res.prio;
            out_occ_reg    <= res.occupancy;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.head_data     = out_data_reg;
    assign rsp.head_priority = out_prio_reg;
    assign rsp.occupancy     = out_occ_reg;

    // A waiting result is never overwritten.
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(out_status_reg) &&
                                       $stable(out_occ_reg)))
        else $error("pending result lost");

    // Only a full queue reports full, and a full report never changes occupancy.
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status == spq_pkg::STATUS_FULL) |->
            res.occupancy == spq_pkg::OCC_W'(QUEUE_DEPTH))
        else $error("full status with room left");

    // An empty status always comes with zero data, priority and occupancy.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status == spq_pkg::STATUS_EMPTY) |->
            (res.data == '0 && res.prio == '0 && res.occupancy == '0))
        else $error("empty status with nonzero fields");

endmodule
